### rtl/core/xbm_pkg.sv
// Shared types and constants for the bitmap raster unpacker.
package xbm_pkg;

  localparam int WORD_W  = 16;  // raster word
  localparam int PIXEL_W = 8;   // output pixel value
  localparam int WIDTH_W = 13;  // image_width register
  localparam int POS_W   = 13;  // bit position within a row
  localparam int LIM_W   = 14;  // row length in bits, up to 8192
  localparam int OFF_W   = 11;  // byte offset / byte counts within a row
  localparam int CFG_W   = 13;  // widest register
  localparam int IDX_W   = 2;   // register index

  localparam int MAX_WIDTH_DEFAULT   = 4096;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // Register indexes on the configuration port.
  typedef enum logic [IDX_W-1:0] {
    REG_IMAGE_WIDTH      = 2'd0,
    REG_SIXTEEN_BIT_MODE = 2'd1,
    REG_BLACK_VALUE      = 2'd2,
    REG_WHITE_VALUE      = 2'd3
  } cfg_reg_t;

  // Row geometry, derived when image_width is written.
  typedef struct packed {
    logic [WIDTH_W-1:0] eff_width;   // clamped width
    logic [OFF_W-1:0]   data_bytes;  // ceil(width/8)
    logic [OFF_W-1:0]   row_bytes;   // data bytes plus X10 padding byte
    logic               sixteen;     // X10 words
  } row_cfg_t;

  // One queued word: raw bits and the mask of bits that become pixels.
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] keep;
  } word_entry_t;

endpackage

### rtl/core/xbm_ifs.sv
// Valid/ready stream interfaces for raster words and pixels.
interface xbm_raster_if;
  logic                      valid;
  logic                      ready;
  logic [xbm_pkg::WORD_W-1:0] raster_word;

  modport source (output valid, output raster_word, input ready);
  modport sink   (input valid, input raster_word, output ready);
endinterface

interface xbm_pixel_if;
  logic                       valid;
  logic                       ready;
  logic [xbm_pkg::PIXEL_W-1:0] pixel_value;
  logic                       run_last;

  modport source (output valid, output pixel_value, output run_last, input ready);
  modport sink   (input valid, input pixel_value, input run_last, output ready);
endinterface

### rtl/core/xbm_raster_unpack.sv
// Top level of the monochrome bitmap raster unpacker.
//
// Usage: raster words enter on the "raster" valid/ready channel, one
// transfer per word (X11 mode uses the low byte only, X10 mode the full
// 16 bits, low byte first). Pixels leave on the "pixel" channel, one
// transfer per pixel, least significant bit first; run_last marks the
// last pixel that a word produced. Words whose bits all fall past the
// image width produce no transfer at all.
// Configuration: cfg_we/cfg_index/cfg_data write image_width (0),
// sixteen_bit_mode (1), black_value (2), white_value (3); change them
// only while no pixel is pending. Row geometry is derived at the write.
// Path: a word's pixels pass through the word queue, the current-word
// register and the output register. Throughput: one pixel per cycle
// while the receiver is ready (single-bit emitter, up to 16 per word).
// The classifier takes a word per cycle while the word queue has room.
// Reset (synchronous, rst high) clears row position, byte offset, the
// queue and the output stage, and loads the register reset values.
// A stalled receiver holds the output register; the queue then fills
// and raster.ready drops.
module xbm_raster_unpack #(
  parameter int MAX_WIDTH   = xbm_pkg::MAX_WIDTH_DEFAULT,
  parameter int QUEUE_DEPTH = xbm_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [xbm_pkg::IDX_W-1:0]  cfg_index,
  input  logic [xbm_pkg::CFG_W-1:0]  cfg_data,
  xbm_raster_if.sink                 raster,
  xbm_pixel_if.source                pixel
);

  // Largest usable width: the register field or MAX_WIDTH, whichever is less.
  localparam int WIDTH_FIELD_MAX = (1 << xbm_pkg::WIDTH_W) - 1;
  localparam logic [xbm_pkg::WIDTH_W-1:0] WIDTH_CAP =
    (MAX_WIDTH > WIDTH_FIELD_MAX) ? xbm_pkg::WIDTH_W'(WIDTH_FIELD_MAX)
                                  : xbm_pkg::WIDTH_W'(MAX_WIDTH);

  xbm_pkg::row_cfg_t             row_cfg;
  logic [xbm_pkg::PIXEL_W-1:0]   black_value;
  logic [xbm_pkg::PIXEL_W-1:0]   white_value;

  // Geometry of a width being written.
  logic [xbm_pkg::WIDTH_W-1:0]   w_in;
  logic [xbm_pkg::WIDTH_W-1:0]   w_eff;
  logic [xbm_pkg::LIM_W-1:0]     w_round;
  logic [xbm_pkg::OFF_W-1:0]     w_bytes;
  logic                          w_pad;

  always_comb begin
    w_in = cfg_data[xbm_pkg::WIDTH_W-1:0];
    if (w_in == '0) begin
      w_eff = xbm_pkg::WIDTH_W'(1);
    end else if (w_in > WIDTH_CAP) begin
      w_eff = WIDTH_CAP;
    end else begin
      w_eff = w_in;
    end
    w_round = {1'b0, w_eff} + xbm_pkg::LIM_W'(7);
    w_bytes = xbm_pkg::OFF_W'(w_round >> 3);
    // X10 rows get a padding byte when width mod 16 is 1..8
    w_pad   = (w_eff[3:0] != 4'd0) && (w_eff[3:0] <= 4'd8);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      // width 1: one data byte plus the X10 padding byte
      row_cfg.eff_width  <= xbm_pkg::WIDTH_W'(1);
      row_cfg.data_bytes <= xbm_pkg::OFF_W'(1);
      row_cfg.row_bytes  <= xbm_pkg::OFF_W'(2);
      row_cfg.sixteen    <= 1'b0;
      black_value        <= xbm_pkg::PIXEL_W'(1);
      white_value        <= '0;
    end else if (cfg_we) begin
      unique case (xbm_pkg::cfg_reg_t'(cfg_index))
        xbm_pkg::REG_IMAGE_WIDTH: begin
          row_cfg.eff_width  <= w_eff;
          row_cfg.data_bytes <= w_bytes;
          row_cfg.row_bytes  <= w_bytes + xbm_pkg::OFF_W'(w_pad);
        end
        xbm_pkg::REG_SIXTEEN_BIT_MODE: row_cfg.sixteen <= cfg_data[0];
        xbm_pkg::REG_BLACK_VALUE:      black_value <= cfg_data[xbm_pkg::PIXEL_W-1:0];
        xbm_pkg::REG_WHITE_VALUE:      white_value <= cfg_data[xbm_pkg::PIXEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Front end -> word queue -> back end.
  xbm_pkg::word_entry_t push_entry;
  xbm_pkg::word_entry_t pop_entry;
  logic                 q_push;
  logic                 q_pop;
  logic                 q_full;
  logic                 q_empty;

  xbm_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (row_cfg),
    .raster  (raster),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (push_entry)
  );

  xbm_fifo #(
    .WIDTH ($bits(xbm_pkg::word_entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_entry),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_entry),
    .empty     (q_empty)
  );

  xbm_back u_back (
    .clk         (clk),
    .rst         (rst),
    .black_value (black_value),
    .white_value (white_value),
    .q_empty     (q_empty),
    .q_entry     (pop_entry),
    .q_pop       (q_pop),
    .pixel       (pixel)
  );

endmodule

### rtl/core/xbm_fifo.sv
// Small flip-flop queue between the word classifier and the pixel emitter.
module xbm_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = xbm_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  assign pop_data = mem[rd_ptr];
  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);

endmodule

### rtl/core/xbm_front.sv
// Word classifier: tracks row position and offset, builds the pixel keep mask.
module xbm_front (
  input  logic              clk,
  input  logic              rst,
  input  xbm_pkg::row_cfg_t cfg,
  xbm_raster_if.sink        raster,
  input  logic              q_full,
  output logic              q_push,
  output xbm_pkg::word_entry_t q_entry
);

  // Which of the byte's eight bits land inside the image width.
  function automatic logic [7:0] byte_keep(
    input logic [xbm_pkg::POS_W-1:0]   p,
    input logic [xbm_pkg::LIM_W-1:0]   lim,
    input logic [xbm_pkg::WIDTH_W-1:0] w
  );
    logic                      stale;
    logic [xbm_pkg::LIM_W-1:0] s;
    logic [xbm_pkg::LIM_W-1:0] pos;
    logic [7:0]                keep;
    stale = ({1'b0, p} >= lim);
    for (int k = 0; k < 8; k++) begin
      s = {1'b0, p} + xbm_pkg::LIM_W'(k);
      if (k == 0) begin
        pos = {1'b0, p};
      end else if (stale) begin
        // left over from a wider row: wraps on the first bit
        pos = xbm_pkg::LIM_W'(k - 1);
      end else if (s >= lim) begin
        pos = s - lim;
      end else begin
        pos = s;
      end
      keep[k] = (pos < {1'b0, w});
    end
    return keep;
  endfunction

  // Bit position after one byte.
  function automatic logic [xbm_pkg::POS_W-1:0] byte_next(
    input logic [xbm_pkg::POS_W-1:0] p,
    input logic [xbm_pkg::LIM_W-1:0] lim
  );
    logic [xbm_pkg::LIM_W-1:0] s;
    logic [xbm_pkg::POS_W-1:0] nxt;
    s = {1'b0, p} + xbm_pkg::LIM_W'(8);
    if ({1'b0, p} >= lim) begin
      nxt = xbm_pkg::POS_W'(7);
    end else if (s >= lim) begin
      nxt = xbm_pkg::POS_W'(s - lim);
    end else begin
      nxt = s[xbm_pkg::POS_W-1:0];
    end
    return nxt;
  endfunction

  logic [xbm_pkg::POS_W-1:0] bit_pos;
  logic [xbm_pkg::POS_W-1:0] bit_pos_next;
  logic [xbm_pkg::OFF_W-1:0] byte_off;
  logic [xbm_pkg::OFF_W-1:0] byte_off_next;

  logic [xbm_pkg::LIM_W-1:0] lim;
  logic [7:0]                keep0;
  logic [7:0]                keep1;
  logic [xbm_pkg::POS_W-1:0] pos1;
  logic [xbm_pkg::POS_W-1:0] pos2;
  logic [xbm_pkg::OFF_W:0]   off_plus1;
  logic [xbm_pkg::OFF_W:0]   off_plus2;
  logic                      pad;
  logic                      row_last;
  logic                      skip_high;
  logic                      accept;

  always_comb begin
    lim       = {cfg.data_bytes, 3'b000};
    keep0     = byte_keep(bit_pos, lim, cfg.eff_width);
    pos1      = byte_next(bit_pos, lim);
    keep1     = byte_keep(pos1, lim, cfg.eff_width);
    pos2      = byte_next(pos1, lim);
    off_plus1 = {1'b0, byte_off} + 1'b1;
    off_plus2 = {1'b0, byte_off} + 2'd2;
    pad       = (cfg.row_bytes != cfg.data_bytes);
    row_last  = (off_plus2 >= {1'b0, cfg.row_bytes});
    skip_high = pad && row_last;

    if (cfg.sixteen) begin
      q_entry.word  = raster.raster_word;
      q_entry.keep  = {(skip_high ? 8'h00 : keep1), keep0};
      bit_pos_next  = skip_high ? pos1 : pos2;
      byte_off_next = row_last ? '0 : off_plus2[xbm_pkg::OFF_W-1:0];
    end else begin
      q_entry.word  = {8'h00, raster.raster_word[7:0]};
      q_entry.keep  = {8'h00, keep0};
      bit_pos_next  = pos1;
      byte_off_next = (off_plus1 >= {1'b0, cfg.data_bytes}) ?
                      '0 : off_plus1[xbm_pkg::OFF_W-1:0];
    end
  end

  assign raster.ready = !q_full;
  assign accept       = raster.valid && !q_full;
  // words with no pixel inside the width leave nothing for the back end
  assign q_push       = accept && (q_entry.keep != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_pos  <= '0;
      byte_off <= '0;
    end else if (accept) begin
      bit_pos  <= bit_pos_next;
      byte_off <= byte_off_next;
    end
  end

endmodule

### rtl/core/xbm_back.sv
// Pixel emitter: one kept bit per unstalled cycle, registered output.
module xbm_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [xbm_pkg::PIXEL_W-1:0]  black_value,
  input  logic [xbm_pkg::PIXEL_W-1:0]  white_value,
  input  logic                         q_empty,
  input  xbm_pkg::word_entry_t         q_entry,
  output logic                         q_pop,
  xbm_pixel_if.source                  pixel
);

  logic [xbm_pkg::WORD_W-1:0] cur_word;
  logic [xbm_pkg::WORD_W-1:0] cur_keep;
  logic [xbm_pkg::WORD_W-1:0] low_bit;
  logic [xbm_pkg::WORD_W-1:0] keep_after;
  logic                       out_valid;
  logic [xbm_pkg::PIXEL_W-1:0] out_pixel;
  logic                       out_last;
  logic                       advance;
  logic                       emit;
  logic                       cur_free;

  always_comb begin
    advance    = !out_valid || pixel.ready;
    emit       = advance && (cur_keep != '0);
    low_bit    = cur_keep & (~cur_keep + 1'b1);  // lowest kept bit
    keep_after = cur_keep & ~low_bit;
    cur_free   = (cur_keep == '0) || (emit && (keep_after == '0));
    q_pop      = cur_free && !q_empty;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_keep  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_keep <= q_entry.keep;
      end else if (emit) begin
        cur_keep <= keep_after;
      end
      if (advance) begin
        out_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_word <= q_entry.word;
    end
    if (emit) begin
      out_pixel <= ((cur_word & low_bit) != '0) ? black_value : white_value;
      out_last  <= (keep_after == '0);
    end
  end

  assign pixel.valid       = out_valid;
  assign pixel.pixel_value = out_pixel;
  assign pixel.run_last    = out_last;

endmodule

### tb/sv/tb_xbm_raster_unpack.sv
// Self-checking testbench for xbm_raster_unpack: predicts pixels per raster word and checks them.

// Pixel expected on the output channel.
typedef struct packed {
  logic [xbm_pkg::PIXEL_W-1:0] pix;
  logic                        run_last;
} pixel_exp_t;

class pixel_scoreboard;
  // Register copies
  logic [xbm_pkg::WIDTH_W-1:0] width_reg;
  logic                        mode16;
  logic [xbm_pkg::PIXEL_W-1:0] black;
  logic [xbm_pkg::PIXEL_W-1:0] white;
  // Row state
  int unsigned bit_pos;
  int unsigned byte_off;

  pixel_exp_t pixel_queue[$];
  pixel_exp_t word_pixels[$];
  int errors;

  function new();
    width_reg = xbm_pkg::WIDTH_W'(1);
    mode16    = 1'b0;
    black     = 8'd1;
    white     = 8'd0;
    bit_pos   = 0;
    byte_off  = 0;
    errors    = 0;
  endfunction

  function void write_reg(xbm_pkg::cfg_reg_t idx, logic [xbm_pkg::CFG_W-1:0] data);
    case (idx)
      xbm_pkg::REG_IMAGE_WIDTH:      width_reg = data[xbm_pkg::WIDTH_W-1:0];
      xbm_pkg::REG_SIXTEEN_BIT_MODE: mode16 = data[0];
      xbm_pkg::REG_BLACK_VALUE:      black = data[xbm_pkg::PIXEL_W-1:0];
      xbm_pkg::REG_WHITE_VALUE:      white = data[xbm_pkg::PIXEL_W-1:0];
      default: ;
    endcase
  endfunction

  // LSB first; positions at or past the width are dropped.
  function void expand_byte(logic [7:0] b, int unsigned w, int unsigned lim);
    pixel_exp_t p;
    for (int i = 0; i < 8; i++) begin
      if (bit_pos < w) begin
        p.pix      = b[i] ? black : white;
        p.run_last = 1'b0;
        word_pixels.push_back(p);
      end
      bit_pos++;
      if (bit_pos >= lim) bit_pos = 0;
    end
  endfunction

  function void accept_word(logic [xbm_pkg::WORD_W-1:0] word);
    int unsigned w;
    int unsigned data_bytes;
    int unsigned lim;
    int unsigned row_bytes;
    bit padded;
    bit row_end;
    w = width_reg;
    if (w < 1) w = 1;
    if (w > xbm_pkg::MAX_WIDTH_DEFAULT) w = xbm_pkg::MAX_WIDTH_DEFAULT;
    data_bytes = (w + 7) / 8;
    lim = data_bytes * 8;
    word_pixels.delete();
    if (mode16) begin
      padded    = (w % 16 >= 1) && (w % 16 <= 8);
      row_bytes = data_bytes + padded;
      row_end   = (byte_off + 2) >= row_bytes;
      expand_byte(word[7:0], w, lim);
      // padding byte sits in the high half of the row's last word
      if (!padded || !row_end) expand_byte(word[15:8], w, lim);
      byte_off = row_end ? 0 : byte_off + 2;
    end else begin
      expand_byte(word[7:0], w, lim);
      byte_off = (byte_off + 1 >= data_bytes) ? 0 : byte_off + 1;
    end
    if (word_pixels.size() > 0) word_pixels[word_pixels.size() - 1].run_last = 1'b1;
    foreach (word_pixels[i]) pixel_queue.push_back(word_pixels[i]);
  endfunction

  function int pixels_owed();
    return pixel_queue.size();
  endfunction

  task report_mismatch(string msg);
    errors++;
    // keep the log bounded on a badly broken build
    if (errors <= 100) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task check_pixel(logic [xbm_pkg::PIXEL_W-1:0] pv, logic lst);
    pixel_exp_t want;
    if (pixel_queue.size() == 0) begin
      report_mismatch($sformatf("pixel %02h arrived with nothing expected", pv));
      return;
    end
    want = pixel_queue.pop_front();
    if (pv !== want.pix)
      report_mismatch($sformatf("pixel_value %02h, expected %02h", pv, want.pix));
    if (lst !== want.run_last)
      report_mismatch($sformatf("run_last %b, expected %b", lst, want.run_last));
  endtask
endclass

module tb_xbm_raster_unpack;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_WORDS     = 410;  // stimulus stops after this many words
  localparam int CALM_WORDS  = 60;   // tail of the run with no idling
  localparam int HOLD_CYCLES = 150;  // long receiver hold-off
  localparam int STALL_LIMIT = 1000; // cycles with no transfer before giving up
  localparam int HOLD_PHASE  = 2;
  localparam int PAUSE_PHASE = 5;

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [xbm_pkg::IDX_W-1:0] cfg_index;
  logic [xbm_pkg::CFG_W-1:0] cfg_data;

  xbm_raster_if raster_ch ();
  xbm_pixel_if  pixel_ch ();

  xbm_raster_unpack u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .raster    (raster_ch),
    .pixel     (pixel_ch)
  );

  pixel_scoreboard sb = new();

  // calm and hold_req are shared between the sender and the receiver processes.
  bit calm;       // no idling on either side
  bit hold_req;   // sender asks the receiver for one long hold-off
  int sent;
  int stall_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------
  // Output side: every pixel transfer is checked against the oldest
  // expectation. Inputs are noted by the send task itself, so the
  // drain logic never races with a word accepted in the same step.
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && pixel_ch.valid && pixel_ch.ready)
      sb.check_pixel(pixel_ch.pixel_value, pixel_ch.run_last);
  end

  // Watchdog: counts cycles in which neither channel moves a transfer.
  always @(posedge clk) begin
    if (rst || (raster_ch.valid && raster_ch.ready) || (pixel_ch.valid && pixel_ch.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------
  // Receiver: random ready bursts, one long hold-off on request (the
  // word queue fills and raster.ready must drop), always ready once
  // the run goes calm. One ready update per iteration.
  // ---------------------------------------------------------------
  initial begin
    pixel_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        pixel_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        pixel_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        pixel_ch.ready <= 1'b1;
        repeat (calm ? 1 : $urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // Register writes, back to back; the enable drops after the last one
  // so it is never lowered and raised within one step.
  task automatic write_cfg(xbm_pkg::cfg_reg_t idx, logic [xbm_pkg::CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic configure(logic [xbm_pkg::WIDTH_W-1:0] width, bit mode,
                           logic [xbm_pkg::PIXEL_W-1:0] blk,
                           logic [xbm_pkg::PIXEL_W-1:0] wht);
    write_cfg(xbm_pkg::REG_IMAGE_WIDTH, xbm_pkg::CFG_W'(width));
    write_cfg(xbm_pkg::REG_SIXTEEN_BIT_MODE, xbm_pkg::CFG_W'(mode));
    write_cfg(xbm_pkg::REG_BLACK_VALUE, xbm_pkg::CFG_W'(blk));
    write_cfg(xbm_pkg::REG_WHITE_VALUE, xbm_pkg::CFG_W'(wht));
    cfg_we <= 1'b0;
  endtask

  // Random sender gap, none once calm.
  task automatic sender_gap();
    if (!calm && $urandom_range(0, 4) == 0) begin
      raster_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // valid stays high from one word to the next unless a gap drops it; the
  // transfer is taken at the edge where ready is seen high.
  task automatic send_word(logic [xbm_pkg::WORD_W-1:0] word);
    raster_ch.valid       <= 1'b1;
    raster_ch.raster_word <= word;
    do @(posedge clk); while (!raster_ch.ready);
    sb.accept_word(word);
    sent++;
  endtask

  task automatic send_words(logic [xbm_pkg::WORD_W-1:0] words[$]);
    foreach (words[i]) begin
      sender_gap();
      send_word(words[i]);
    end
  endtask

  // Stop offering and wait until every expected pixel has arrived, then
  // let the pipe settle.
  task automatic drain();
    raster_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pixels_owed() != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic [xbm_pkg::WIDTH_W-1:0] width;
    int                          n_words;
    int                          phase;
    logic [xbm_pkg::WORD_W-1:0]  word;

    rst                   <= 1'b1;
    cfg_we                <= 1'b0;
    cfg_index             <= xbm_pkg::REG_IMAGE_WIDTH;
    cfg_data              <= '0;
    raster_ch.valid       <= 1'b0;
    raster_ch.raster_word <= '0;
    calm         = 1'b0;
    hold_req     = 1'b0;
    sent         = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed part ----
    // Register reset values: one-pixel rows, high byte ignored in byte mode.
    send_words('{16'h0001, 16'hFFFE});
    drain();
    // Width 0 acts as 1.
    configure(13'd0, 1'b0, 8'hFF, 8'h00);
    send_words('{16'hFFFF});
    drain();
    // Width above the maximum acts as the maximum, sixteen-bit words.
    configure(13'd8191, 1'b1, 8'h00, 8'hFF);
    send_words('{16'h0000, 16'hFFFF, 16'hAAAA});
    drain();
    // Padded rows: width 20 leaves a padding byte, high half of the
    // row's last word is skipped.
    configure(13'd20, 1'b1, 8'hA5, 8'h5A);
    send_words('{16'h5555, 16'hFF00, 16'h00FF, 16'h1234});
    drain();
    // Width a multiple of 16: no padding, one word per row.
    configure(13'd16, 1'b1, 8'hFF, 8'h00);
    send_words('{16'h8001, 16'h7FFE});
    drain();
    // Bits past the width dropped within the row's last byte.
    configure(13'd12, 1'b0, 8'h00, 8'hFF);
    send_words('{16'h00FF, 16'hA50F, 16'h5AF0});
    drain();
    // Widest row in byte mode.
    configure(13'd4096, 1'b0, 8'h80, 8'h7F);
    send_words('{16'h3C96, 16'hC369});
    drain();
    // Leave the row mid-way, then shrink the width so position and
    // byte offset are already past the new row length.
    configure(13'd40, 1'b0, 8'h11, 8'hEE);
    send_words('{16'hF00F, 16'h0FF0});
    drain();
    configure(13'd9, 1'b0, 8'h33, 8'hCC);
    send_words('{16'h6699, 16'h9966});
    drain();

    // ---- random part ----
    phase = 0;
    while (sent < N_WORDS) begin
      case ($urandom_range(0, 9))
        0: begin
          case ($urandom_range(0, 4))
            0:       width = 13'd0;
            1:       width = 13'd1;
            2:       width = 13'd4096;
            3:       width = 13'd4097;
            default: width = 13'd8191;
          endcase
        end
        1, 2:    width = xbm_pkg::WIDTH_W'($urandom_range(41, 300));
        default: width = xbm_pkg::WIDTH_W'($urandom_range(1, 40));
      endcase
      configure(width, 1'($urandom_range(0, 1)),
                xbm_pkg::PIXEL_W'($urandom_range(0, 255)),
                xbm_pkg::PIXEL_W'($urandom_range(0, 255)));

      // long rows only get a handful of words
      n_words = (width > 300 || width == 0) ? $urandom_range(4, 10) : $urandom_range(12, 30);
      if (phase == HOLD_PHASE) begin
        n_words  = 30;
        hold_req = 1'b1;
      end

      for (int k = 0; k < n_words; k++) begin
        if (sent >= N_WORDS - CALM_WORDS) calm = 1'b1;
        // sender pause until every pixel so far has come out
        if (phase == PAUSE_PHASE && k == n_words / 2) drain();
        sender_gap();
        case ($urandom_range(0, 7))
          0:       word = 16'h0000;
          1:       word = 16'hFFFF;
          default: word = xbm_pkg::WORD_W'($urandom_range(0, 65535));
        endcase
        send_word(word);
      end
      drain();
      phase++;
    end

    repeat (20) @(posedge clk);
    if (sb.pixels_owed() != 0)
      sb.report_mismatch($sformatf("%0d pixels never arrived", sb.pixels_owed()));
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/xbm_pkg.sv
rtl/core/xbm_ifs.sv
rtl/core/xbm_fifo.sv
rtl/core/xbm_front.sv
rtl/core/xbm_back.sv
rtl/core/xbm_raster_unpack.sv
tb/sv/tb_xbm_raster_unpack.sv
